// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects clk in the scope where it is used; ASSERT_RST also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check only while out of reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, prop, msg)
`define ASSERT_ANY(label, prop, msg)

`endif

`endif

// File: rtl/apsp_pkg.sv
package apsp_pkg;

    // Graph size and derived address widths
    localparam int NODES     = 64;
    localparam int NODE_W    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int ADDR_W    = 2 * NODE_W;

    // Field widths
    localparam int ID_W      = 6;
    localparam int WEIGHT_W  = 16;
    localparam int DIST_W    = 24;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] UNREACH    = 24'hFFFFFF;
    localparam logic [DIST_W-1:0] MAX_FINITE = 24'hFFFFFE;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 2'd2;

    // Configuration reset values
    localparam logic [ID_W-1:0] TARGET_RST = 6'd51;
    localparam logic [ID_W-1:0] FIRST_RST  = 6'd26;
    localparam logic [ID_W-1:0] LAST_RST   = 6'd50;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ID_W-1:0]     node_a;
        logic [ID_W-1:0]     node_b;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   best_node;
        logic [DIST_W-1:0] best_distance;
        logic              found;
    } out_item_t;

    // Control from the sequencer to the nearest-node tracker
    typedef struct packed {
        logic              start;
        logic              sample_vld;
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
    } scan_ctl_t;

endpackage

// File: rtl/all_pairs_shortest_path_nearest_top.sv
// Add edge: a read of the edge entry, then two write-backs (S_ADD_WR1, S_ADD_WR2) before the next accepted item.
// Clear: the matrix memory is swept one entry per cycle (4096 entries).
// Solve: relaxation over every pivot, row and column, one matrix entry per cycle on the
//   shared RAM, then a scan of the source range and a report (no scan if the range is empty).
// Reset: config returns to target 51, sources 26..50, and a clearing pass over all 4096
//   entries runs before the first input transfer; config writes are taken at any time.
`include "assert_macros.svh"

module all_pairs_shortest_path_nearest_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input item channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  apsp_pkg::in_item_t                   in_data,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output apsp_pkg::out_item_t                  out_data,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [apsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [apsp_pkg::ID_W-1:0]            cfg_data
);

    localparam int NODES     = apsp_pkg::NODES;
    localparam int NODE_W    = apsp_pkg::NODE_W;
    localparam int ADDR_W    = apsp_pkg::ADDR_W;
    localparam int DIST_W    = apsp_pkg::DIST_W;
    localparam int ID_W      = apsp_pkg::ID_W;
    localparam int WEIGHT_W  = apsp_pkg::WEIGHT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

    // Sequencer states
    localparam logic [3:0] S_CLEAR      = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_ADD_WR1    = 4'd2;
    localparam logic [3:0] S_ADD_WR2    = 4'd3;
    localparam logic [3:0] S_REL_PRE    = 4'd4;
    localparam logic [3:0] S_REL_ROW    = 4'd5;
    localparam logic [3:0] S_REL_NEXT   = 4'd6;
    localparam logic [3:0] S_SCAN_START = 4'd7;
    localparam logic [3:0] S_SCAN       = 4'd8;
    localparam logic [3:0] S_SCAN_DRAIN = 4'd9;
    localparam logic [3:0] S_REPORT     = 4'd10;

    // Saturating distance add: unreachable absorbs, finite sums clip below it.
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
                                                  input logic [DIST_W-1:0] y);
        logic [DIST_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if ((x == apsp_pkg::UNREACH) || (y == apsp_pkg::UNREACH))
            return apsp_pkg::UNREACH;
        else if (s > {1'b0, apsp_pkg::MAX_FINITE})
            return apsp_pkg::MAX_FINITE;
        else
            return s[DIST_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [3:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;

    // relaxation counters: k is the pivot, i the row, j the column
    logic [NODE_W-1:0]   k_reg, k_next;
    logic [NODE_W-1:0]   i_reg, i_next;
    logic [NODE_W-1:0]   j_reg, j_next;
    logic [DIST_W-1:0]   dik_reg, dik_next;
    logic                pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0]   pipe_addr_reg, pipe_addr_next;

    // held edge for the add command
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                upd_reg, upd_next;

    // nearest-source scan
    logic [NODE_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [NODE_W-1:0]   hi_reg, hi_next;
    logic                scan_vld_reg, scan_vld_next;
    logic [NODE_W-1:0]   scan_node_reg, scan_node_next;

    // configuration
    logic [ID_W-1:0]     target_reg, target_next;
    logic [ID_W-1:0]     first_reg, first_next;
    logic [ID_W-1:0]     last_reg, last_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    apsp_pkg::out_item_t out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Distance matrix: one write port, two read ports, registered reads.
    // Address is {row, column}.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0]   mem [MEM_DEPTH];
    logic [DIST_W-1:0]   mem_rd_a_reg;
    logic [DIST_W-1:0]   mem_rd_b_reg;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DIST_W-1:0]   mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rd_a_reg <= mem[rd_addr_a];
        mem_rd_b_reg <= mem[rd_addr_b];
    end

    // ------------------------------------------------------------------
    // Nearest-node tracker
    // ------------------------------------------------------------------
    apsp_pkg::scan_ctl_t scan_ctl;
    apsp_pkg::out_item_t scan_result;

    apsp_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .result (scan_result)
    );

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_fire;
    logic a_ok;
    logic b_ok;
    logic scan_empty;
    logic [NODE_W-1:0] hi_clip;
    logic [DIST_W-1:0] relax_cand;
    logic              relax_wr;

    // Take a new item only between commands; a waiting result does not block it.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Edge endpoints outside the graph drop the add.
    assign a_ok = (int'(in_data.node_a) < NODES);
    assign b_ok = (int'(in_data.node_b) < NODES);

    // Source range clipped to the graph; empty when reversed or target is outside.
    assign hi_clip    = (int'(last_reg) < NODES) ? NODE_W'(last_reg) : NODE_LAST;
    assign scan_empty = (int'(first_reg) > int'(hi_clip)) || (int'(target_reg) >= NODES);

    // Relaxation datapath: d[i][k] is held, d[k][j] on port A, d[i][j] on port B.
    // Row k and column k do not change during pivot k, since the diagonal stays zero,
    // so each write lands on a different entry than any read in flight.
    assign relax_cand = sat_add(dik_reg, mem_rd_a_reg);
    assign relax_wr   = pipe_vld_reg && (relax_cand < mem_rd_b_reg);

    always_comb
    begin
        scan_ctl.start      = (state_reg == S_SCAN_START);
        scan_ctl.sample_vld = scan_vld_reg;
        scan_ctl.node       = scan_node_reg;
        scan_ctl.distance   = mem_rd_a_reg;
    end

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_comb
    begin
        target_next = target_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                apsp_pkg::CFG_TARGET: target_next = cfg_data;
                apsp_pkg::CFG_FIRST:  first_next  = cfg_data;
                apsp_pkg::CFG_LAST:   last_next   = cfg_data;
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        dik_next       = dik_reg;
        pipe_vld_next  = 1'b0;
        pipe_addr_next = pipe_addr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        upd_next       = upd_reg;
        scan_idx_next  = scan_idx_reg;
        hi_next        = hi_reg;
        scan_vld_next  = 1'b0;
        scan_node_next = scan_node_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        rd_addr_a      = {k_reg, j_reg};
        rd_addr_b      = {NODE_W'(in_data.node_a), NODE_W'(in_data.node_b)};
        mem_we         = 1'b0;
        mem_waddr      = pipe_addr_reg;
        mem_wdata      = relax_cand;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every entry: zero on the diagonal, unreachable elsewhere
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = (clr_addr_reg[ADDR_W-1:NODE_W] == clr_addr_reg[NODE_W-1:0])
                                ? '0 : apsp_pkg::UNREACH;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                // port B already reads the edge entry for an add
                if (in_fire)
                begin
                    case (in_data.command)
                        apsp_pkg::CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        apsp_pkg::CMD_ADD:
                        begin
                            if (a_ok && b_ok)
                            begin
                                a_next     = NODE_W'(in_data.node_a);
                                b_next     = NODE_W'(in_data.node_b);
                                w_next     = in_data.weight;
                                state_next = S_ADD_WR1;
                            end
                        end
                        apsp_pkg::CMD_SOLVE:
                        begin
                            k_next     = '0;
                            i_next     = '0;
                            state_next = S_REL_PRE;
                        end
                        default: ;
                    endcase
                end
            end

            S_ADD_WR1:
            begin
                // store only a strictly shorter edge
                upd_next   = (DIST_W'(w_reg) < mem_rd_b_reg);
                mem_we     = upd_next;
                mem_waddr  = {a_reg, b_reg};
                mem_wdata  = DIST_W'(w_reg);
                state_next = S_ADD_WR2;
            end

            S_ADD_WR2:
            begin
                mem_we     = upd_reg;
                mem_waddr  = {b_reg, a_reg};
                mem_wdata  = DIST_W'(w_reg);
                state_next = S_IDLE;
            end

            S_REL_PRE:
            begin
                // fetch d[i][k] for the whole row
                rd_addr_b  = {i_reg, k_reg};
                j_next     = '0;
                state_next = S_REL_ROW;
            end

            S_REL_ROW:
            begin
                if (j_reg == '0)
                    dik_next = mem_rd_b_reg;
                rd_addr_a      = {k_reg, j_reg};
                rd_addr_b      = {i_reg, j_reg};
                pipe_vld_next  = 1'b1;
                pipe_addr_next = {i_reg, j_reg};
                if (j_reg == NODE_LAST)
                    state_next = S_REL_NEXT;
                else
                    j_next = j_reg + 1'b1;
            end

            S_REL_NEXT:
            begin
                // last column of the row retires here; advance row, then pivot
                if (i_reg == NODE_LAST)
                begin
                    i_next = '0;
                    if (k_reg == NODE_LAST)
                        state_next = S_SCAN_START;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_REL_PRE;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_REL_PRE;
                end
            end

            S_SCAN_START:
            begin
                hi_next       = hi_clip;
                scan_idx_next = NODE_W'(first_reg);
                state_next    = scan_empty ? S_REPORT : S_SCAN;
            end

            S_SCAN:
            begin
                // one source per cycle: read d[source][target]
                rd_addr_a      = {scan_idx_reg, NODE_W'(target_reg)};
                scan_vld_next  = 1'b1;
                scan_node_next = scan_idx_reg;
                if (scan_idx_reg == hi_reg)
                    state_next = S_SCAN_DRAIN;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end

            S_SCAN_DRAIN:
            begin
                state_next = S_REPORT;
            end

            S_REPORT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = scan_result;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // relaxation write-back retires one pipeline slot behind the reads
        if (relax_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = pipe_addr_reg;
            mem_wdata = relax_cand;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            pipe_vld_reg  <= 1'b0;
            scan_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= apsp_pkg::TARGET_RST;
            first_reg     <= apsp_pkg::FIRST_RST;
            last_reg      <= apsp_pkg::LAST_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pipe_vld_reg  <= pipe_vld_next;
            scan_vld_reg  <= scan_vld_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        dik_reg       <= dik_next;
        pipe_addr_reg <= pipe_addr_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        upd_reg       <= upd_next;
        scan_idx_reg  <= scan_idx_next;
        hi_reg        <= hi_next;
        scan_node_reg <= scan_node_next;
        out_data_reg  <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_RST(a_relax_skips_pivot_row,
        relax_wr |-> (pipe_addr_reg[ADDR_W-1:NODE_W] != k_reg),
        "relaxation wrote the pivot row")
    `ASSERT_RST(a_relax_no_overlap,
        (state_reg == S_REL_ROW) && mem_we |->
            (rd_addr_a != mem_waddr) && (rd_addr_b != mem_waddr),
        "write-back collides with a read in flight")
    `ASSERT_ANY(a_idle_is_drained,
        !in_stall |-> !pipe_vld_reg && !scan_vld_reg,
        "new item taken with work in flight")
    `ASSERT_RST(a_result_from_report,
        out_valid && !$past(out_valid) |-> $past(state_reg) == S_REPORT,
        "result appeared outside the report step")

endmodule

// File: rtl/apsp_scan.sv
`include "assert_macros.svh"

module apsp_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  apsp_pkg::scan_ctl_t   ctl,
    output apsp_pkg::out_item_t   result
);

    localparam int NODE_W = apsp_pkg::NODE_W;
    localparam int DIST_W = apsp_pkg::DIST_W;
    localparam int ID_W   = apsp_pkg::ID_W;

    logic [NODE_W-1:0] best_node_reg, best_node_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              found_reg, found_next;

    // Keep the first strictly smaller distance, so ties go to the lower id
    always_comb
    begin
        best_node_next = best_node_reg;
        best_dist_next = best_dist_reg;
        found_next     = found_reg;
        if (ctl.start)
        begin
            best_node_next = '0;
            best_dist_next = apsp_pkg::UNREACH;
            found_next     = 1'b0;
        end
        else if (ctl.sample_vld && (ctl.distance < best_dist_reg))
        begin
            best_node_next = ctl.node;
            best_dist_next = ctl.distance;
            found_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_node_reg <= '0;
            best_dist_reg <= apsp_pkg::UNREACH;
            found_reg     <= 1'b0;
        end
        else
        begin
            best_node_reg <= best_node_next;
            best_dist_reg <= best_dist_next;
            found_reg     <= found_next;
        end
    end

    assign result.best_node     = ID_W'(best_node_reg);
    assign result.best_distance = best_dist_reg;
    assign result.found         = found_reg;

    `ASSERT_RST(a_found_iff_finite,
        found_reg == (best_dist_reg != apsp_pkg::UNREACH),
        "found flag disagrees with best distance")
    `ASSERT_RST(a_start_clears,
        ctl.start |=> !found_reg && (best_dist_reg == apsp_pkg::UNREACH),
        "start did not clear the tracker")
    `ASSERT_RST(a_dist_never_grows,
        !ctl.start |=> best_dist_reg <= $past(best_dist_reg),
        "best distance grew during a scan")

endmodule
